>>> design/qse_pkg.sv
// qse_pkg: shared constants, state encoding and compare result type for the
// quicksort engine. No dependencies.
package qse_pkg;

   localparam int MAX_ELEMENTS = 32;
   localparam int DATA_WIDTH   = 32;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int STACK_W      = 2 * IDX_W;

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_RANGE    = 14'b00000000000010,
      ST_PIV_A    = 14'b00000000000100,
      ST_PIV_B    = 14'b00000000001000,
      ST_SCAN_A   = 14'b00000000010000,
      ST_CHK_A    = 14'b00000000100000,
      ST_CHK_B    = 14'b00000001000000,
      ST_SWAP     = 14'b00000010000000,
      ST_SPLIT    = 14'b00000100000000,
      ST_POP      = 14'b00001000000000,
      ST_POP_WAIT = 14'b00010000000000,
      ST_OUT_REQ  = 14'b00100000000000,
      ST_OUT_LOAD = 14'b01000000000000,
      ST_OUT_WAIT = 14'b10000000000000
   } state_type;

   typedef struct packed {
      logic lt;
      logic gt;
   } cmp_type;

endpackage

>>> design/qse_ram.sv
// qse_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module qse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/qse_alu.sv
// qse_alu: shared arithmetic unit; floor average of the range endpoints and
// signed compare of an element against the pivot. Depends on qse_pkg.
module qse_alu (
   input  logic signed [qse_pkg::DATA_WIDTH-1:0] end_a,
   input  logic signed [qse_pkg::DATA_WIDTH-1:0] end_b,
   input  logic signed [qse_pkg::DATA_WIDTH-1:0] element,
   input  logic signed [qse_pkg::DATA_WIDTH-1:0] pivot,
   output logic signed [qse_pkg::DATA_WIDTH-1:0] average,
   output qse_pkg::cmp_type                      cmp
);
   import qse_pkg::*;

   logic signed [DATA_WIDTH:0] sum;

   // 33-bit sum, arithmetic halving gives the floor
   assign sum     = {end_a[DATA_WIDTH-1], end_a} + {end_b[DATA_WIDTH-1], end_b};
   assign average = sum[DATA_WIDTH:1];

   assign cmp.lt = element < pivot;
   assign cmp.gt = element > pivot;

endmodule

>>> design/quicksort_engine.sv
// quicksort_engine: loads up to MAX_ELEMENTS signed values, sorts in place by Hoare
// quicksort with an explicit range stack, streams them out ascending. Uses qse_pkg,
// qse_ram, qse_alu. Loading: one transfer per cycle, not ready while sorting or output.
// Sort: one scan step per cycle; a swap writes one element in ST_CHK_B, the other in
// ST_SWAP. Output: each result is read, registered, then held until rsp_ready.
// Synchronous reset clears the control state; element and stack RAMs are not cleared.
module quicksort_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [qse_pkg::DATA_WIDTH-1:0] req_value,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [qse_pkg::DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                                 rsp_last_out,
   output logic                                 rsp_overflow
);
   import qse_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] sp_ff, sp_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0] a_ff, a_in, b_ff, b_in, j_ff, j_in;
   logic signed [DATA_WIDTH-1:0] va_ff, va_in;
   logic signed [DATA_WIDTH-1:0] pivot_ff, pivot_in;
   logic signed [DATA_WIDTH-1:0] out_value_ff, out_value_in;
   logic                         out_last_ff, out_last_in;

   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr, mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data, mem_rd_data;

   logic                  stk_wr_en;
   logic [IDX_W-1:0]      stk_wr_addr, stk_rd_addr;
   logic [STACK_W-1:0]    stk_wr_data, stk_rd_data;

   logic signed [DATA_WIDTH-1:0] average;
   cmp_type                      cmp;

   logic             in_xfer, out_xfer, room;
   logic [CNT_W-1:0] n_load;
   logic             scan_a_go, scan_b_go;
   logic [IDX_W-1:0] left_len, right_len;

   qse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   qse_ram #(.WIDTH(STACK_W), .DEPTH(MAX_ELEMENTS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   qse_alu u_alu (
      .end_a   (va_ff),
      .end_b   (mem_rd_data),
      .element (mem_rd_data),
      .pivot   (pivot_ff),
      .average (average),
      .cmp     (cmp)
   );

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_OUT_WAIT);
   assign rsp_sorted_value = out_value_ff;
   assign rsp_last_out     = out_last_ff;
   assign rsp_overflow     = ovf_ff;

   assign in_xfer   = req_valid && req_ready;
   assign out_xfer  = rsp_valid && rsp_ready;
   assign room      = (count_ff < CNT_W'(MAX_ELEMENTS));
   assign n_load    = room ? count_ff + CNT_W'(1) : count_ff;
   assign scan_a_go = (a_ff < hi_ff) && cmp.lt;
   assign scan_b_go = (b_ff > lo_ff) && cmp.gt;
   assign left_len  = j_ff - lo_ff;
   assign right_len = hi_ff - (j_ff + IDX_W'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      sp_in        = sp_ff;
      ovf_in       = ovf_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      j_in         = j_ff;
      va_in        = va_ff;
      pivot_in     = pivot_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = a_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_addr  = '0;
      stk_wr_en    = 1'b0;
      stk_wr_addr  = sp_ff[IDX_W-1:0];
      stk_wr_data  = {lo_ff, j_ff};
      stk_rd_addr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_xfer) begin
               if (room) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = count_ff[IDX_W-1:0];
                  mem_wr_data = req_value;
               end else begin
                  ovf_in = 1'b1;
               end
               count_in = n_load;
               if (req_last) begin
                  k_in  = '0;
                  sp_in = '0;
                  lo_in = '0;
                  hi_in = IDX_W'(n_load - CNT_W'(1));
                  state_in = (n_load < CNT_W'(2)) ? ST_OUT_REQ : ST_RANGE;
               end
            end
         end
         ST_RANGE: begin
            mem_rd_addr = lo_ff;
            state_in    = (lo_ff < hi_ff) ? ST_PIV_A : ST_POP;
         end
         ST_PIV_A: begin
            va_in       = mem_rd_data;
            mem_rd_addr = hi_ff;
            state_in    = ST_PIV_B;
         end
         ST_PIV_B: begin
            pivot_in = average;
            a_in     = lo_ff;
            b_in     = hi_ff;
            state_in = ST_SCAN_A;
         end
         ST_SCAN_A: begin
            mem_rd_addr = a_ff;
            state_in    = ST_CHK_A;
         end
         ST_CHK_A: begin
            if (scan_a_go) begin
               a_in        = a_ff + IDX_W'(1);
               mem_rd_addr = a_ff + IDX_W'(1);
            end else begin
               va_in       = mem_rd_data;
               mem_rd_addr = b_ff;
               state_in    = ST_CHK_B;
            end
         end
         ST_CHK_B: begin
            if (scan_b_go) begin
               b_in        = b_ff - IDX_W'(1);
               mem_rd_addr = b_ff - IDX_W'(1);
            end else if (a_ff >= b_ff) begin
               j_in     = (b_ff >= hi_ff) ? hi_ff - IDX_W'(1) : b_ff;
               state_in = ST_SPLIT;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = a_ff;
               mem_wr_data = mem_rd_data;
               state_in    = ST_SWAP;
            end
         end
         ST_SWAP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = b_ff;
            mem_wr_data = va_ff;
            a_in        = a_ff + IDX_W'(1);
            b_in        = b_ff - IDX_W'(1);
            state_in    = ST_SCAN_A;
         end
         ST_SPLIT: begin
            stk_wr_en = (sp_ff < CNT_W'(MAX_ELEMENTS));
            if (stk_wr_en) begin
               sp_in = sp_ff + CNT_W'(1);
            end
            if (left_len < right_len) begin
               stk_wr_data = {j_ff + IDX_W'(1), hi_ff};
               hi_in       = j_ff;
            end else begin
               stk_wr_data = {lo_ff, j_ff};
               lo_in       = j_ff + IDX_W'(1);
            end
            state_in = ST_RANGE;
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               k_in     = '0;
               state_in = ST_OUT_REQ;
            end else begin
               stk_rd_addr = IDX_W'(sp_ff - CNT_W'(1));
               sp_in       = sp_ff - CNT_W'(1);
               state_in    = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            lo_in    = stk_rd_data[STACK_W-1:IDX_W];
            hi_in    = stk_rd_data[IDX_W-1:0];
            state_in = ST_RANGE;
         end
         ST_OUT_REQ: begin
            mem_rd_addr = k_ff[IDX_W-1:0];
            state_in    = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            out_value_in = mem_rd_data;
            out_last_in  = (k_ff == count_ff - CNT_W'(1));
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (out_xfer) begin
               if (out_last_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = ST_OUT_REQ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         k_ff     <= '0;
         sp_ff    <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         k_ff     <= k_in;
         sp_ff    <= sp_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      j_ff         <= j_in;
      va_ff        <= va_in;
      pivot_ff     <= pivot_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

endmodule

>>> verif/quicksort_engine_tb.sv
// quicksort_engine_tb: self-checking bench for quicksort_engine. Loads data sets over
// the req_ channel and checks each sorted rsp_ transfer against a local sort model.
// Depends on qse_pkg and the quicksort_engine RTL.
module quicksort_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qse_pkg::*;

   localparam int CLOCK_PERIOD   = 12;
   localparam int RESET_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 50000;
   localparam int DRAIN_CYCLES   = 100;

   localparam logic signed [DATA_WIDTH-1:0] VALUE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [DATA_WIDTH-1:0] VALUE_MAX = ~VALUE_MIN;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last;
   } load_item_t;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last_out;
      logic                         overflow;
   } sorted_item_t;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [DATA_WIDTH-1:0] req_value = '0;
   logic                         req_last = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [DATA_WIDTH-1:0] rsp_sorted_value;
   logic                         rsp_last_out;
   logic                         rsp_overflow;

   load_item_t   load_queue[$];
   sorted_item_t pending_sorted[$];
   load_item_t   next_load;
   sorted_item_t want;

   logic signed [DATA_WIDTH-1:0] held[MAX_ELEMENTS];
   int           held_count = 0;
   logic         dropped = 1'b0;

   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   logic         req_taken = 1'b0;
   int           quiet_cycles = 0;
   int           error_count = 0;

   quicksort_engine dut (.*);

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string field, input logic [DATA_WIDTH-1:0] exp_val,
                                  input logic [DATA_WIDTH-1:0] got_val);
      $display("MISMATCH %s: expected %0h got %0h at %0t", field, exp_val, got_val, $realtime);
      error_count++;
   endtask

   // Stores one accepted element, or marks a drop when full; a last mark sorts what is held and queues the results.
   task automatic absorb_element(input logic signed [DATA_WIDTH-1:0] value, input logic last);
      sorted_item_t                 item;
      logic signed [DATA_WIDTH-1:0] key;
      int                           i;
      int                           j;
      if (held_count < MAX_ELEMENTS) begin
         held[held_count] = value;
         held_count++;
      end else begin
         dropped = 1'b1;
      end
      if (last) begin
         for (i = 1; i < held_count; i++) begin
            key = held[i];
            j = i - 1;
            while (j >= 0 && held[j] > key) begin
               held[j + 1] = held[j];
               j--;
            end
            held[j + 1] = key;
         end
         for (i = 0; i < held_count; i++) begin
            item.value    = held[i];
            item.last_out = (i == held_count - 1);
            item.overflow = dropped;
            pending_sorted.push_back(item);
         end
         held_count = 0;
         dropped    = 1'b0;
      end
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom;
         1: return int'($urandom_range(8)) - 4;
         2: begin
            case ($urandom_range(3))
               0: return VALUE_MIN;
               1: return VALUE_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return $signed($urandom) >>> $urandom_range(31);
      endcase
   endfunction

   task automatic queue_element(input logic signed [DATA_WIDTH-1:0] value, input logic last);
      load_item_t item;
      item.value = value;
      item.last  = last;
      load_queue.push_back(item);
   endtask

   task automatic queue_set(input int size);
      int i;
      for (i = 0; i < size; i++)
         queue_element(pick_value(), i == size - 1);
   endtask

   // Mostly small sets, some near full, a few past the store depth.
   task automatic queue_random_sets(input int items);
      int added;
      int size;
      int pick;
      added = 0;
      while (added < items) begin
         pick = $urandom_range(99);
         if (pick < 70)
            size = $urandom_range(8, 1);
         else if (pick < 85)
            size = $urandom_range(20, 9);
         else if (pick < 93)
            size = $urandom_range(MAX_ELEMENTS, 21);
         else
            size = $urandom_range(MAX_ELEMENTS + 4, MAX_ELEMENTS + 1);
         queue_set(size);
         added += size;
      end
   endtask

   // Driver: new transfers only once the previous one has gone through.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (load_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_load = load_queue.pop_front();
            req_valid <= 1'b1;
            req_value <= next_load.value;
            req_last  <= next_load.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: predicts on each load transfer and checks each result transfer.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready)
            absorb_element(req_value, req_last);
         if (rsp_valid && rsp_ready) begin
            if (pending_sorted.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_sorted_value);
            end else begin
               want = pending_sorted.pop_front();
               if (rsp_sorted_value !== want.value)
                  report_mismatch("sorted_value", want.value, rsp_sorted_value);
               if (rsp_last_out !== want.last_out)
                  report_mismatch("last_out", DATA_WIDTH'(want.last_out),
                                  DATA_WIDTH'(rsp_last_out));
               if (rsp_overflow !== want.overflow)
                  report_mismatch("overflow", DATA_WIDTH'(want.overflow),
                                  DATA_WIDTH'(rsp_overflow));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      idle_mode_t mode;

      // single element at the top of the range
      queue_element(VALUE_MAX, 1'b1);
      // most negative and most positive pair, pivot sum is -1
      queue_element(VALUE_MIN, 1'b0);
      queue_element(VALUE_MAX, 1'b1);
      // negative pair, floor of the average
      queue_element(-1, 1'b0);
      queue_element(-2, 1'b1);
      // all equal
      queue_element(-3, 1'b0);
      queue_element(-3, 1'b0);
      queue_element(-3, 1'b1);
      // already ascending
      for (int i = 1; i <= 5; i++)
         queue_element(i, i == 5);
      // descending through zero
      for (int i = 5; i >= -1; i--)
         queue_element(i, i == -1);
      queue_element(VALUE_MAX, 1'b0);
      queue_element(VALUE_MIN, 1'b0);
      queue_element('0, 1'b0);
      queue_element(VALUE_MAX, 1'b0);
      queue_element(VALUE_MIN, 1'b1);
      // store overflows, the element with the last mark is dropped
      queue_set(MAX_ELEMENTS + 1);
      queue_random_sets(25);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 4; p++) begin
         @(posedge clock);
         mode = idle_mode_t'(p);
         case (mode)
            IDLE_NONE: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
               send_idle_pct  = 73;
               recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               send_idle_pct  = 0;
               recv_stall_pct = 73;
            end
            default: begin
               send_idle_pct  = 13;
               recv_stall_pct = 13;
            end
         endcase
         if (mode != IDLE_NONE)
            queue_random_sets(55);
         while (load_queue.size() != 0 || req_valid || pending_sorted.size() != 0)
            @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_sorted.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> quicksort_engine.f
design/qse_pkg.sv
design/qse_ram.sv
design/qse_alu.sv
design/quicksort_engine.sv
verif/quicksort_engine_tb.sv
